// ===== hw/rtl/ted_pkg.sv =====
// ted_pkg: shared widths, reset values and register indexes for the
// touch envelope detector. No dependencies.
package ted_pkg;

    localparam int SAMPLE_W            = 16;
    localparam int SHIFT_W             = 4;
    localparam int CFG_INDEX_W         = 2;
    localparam int CFG_DATA_W          = SHIFT_W;

    localparam logic [SHIFT_W-1:0] DECAY_SHIFT_RESET = 4'd5;
    localparam logic [SHIFT_W-1:0] SWING_SHIFT_RESET = 4'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_DECAY_SHIFT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SWING_SHIFT = 2'd1;

endpackage

// ===== hw/rtl/ted_if.sv =====
// ted stream interfaces: sample channel in, touched-flag channel out.
// Depends on ted_pkg for the sample width.
interface ted_sample_if;
    logic                         valid;
    logic                         ready;
    logic [ted_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface ted_result_if;
    logic valid;
    logic ready;
    logic touched;

    modport source (output valid, output touched, input ready);
    modport sink   (input valid, input touched, output ready);
endinterface

// ===== hw/rtl/touch_envelope_detector_unit.sv =====
// touch_envelope_detector_unit: peak/trough envelope tracker and touch decision.
// Depends on ted_pkg and the stream interfaces in ted_if.sv.
//
// One sample item is accepted per clock unless a stalled output holds it up.
// An accepted item sits in an input register, then the envelope update, span
// check and midpoint compare run combinationally against the peak and trough
// registers, which is what bounds the rate: each item sees the envelope left
// by the one before. A decision then goes from there into the output register.
// Items that make no decision, or repeat the last flag, produce nothing; the
// very first sample after reset only loads the envelope. A stalled output
// only holds up the pipe when the next item would also produce a result.
// Configuration writes are meant to happen while no items are in flight.
module touch_envelope_detector_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [ted_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ted_pkg::CFG_DATA_W-1:0]  cfg_data,
    ted_sample_if.sink                      sample_in,
    ted_result_if.source                    result_out
);

    localparam int SAMPLE_BITS = ted_pkg::SAMPLE_W;

    logic [ted_pkg::SHIFT_W-1:0] decay_shift_reg;
    logic [ted_pkg::SHIFT_W-1:0] swing_shift_reg;

    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;

    logic [SAMPLE_BITS-1:0] peak_reg;
    logic [SAMPLE_BITS-1:0] trough_reg;
    logic                   primed_reg;
    logic                   decided_reg;
    logic                   last_touched_reg;

    logic out_valid_reg;
    logic out_touched_reg;

    logic [SAMPLE_BITS-1:0] span_now;
    logic [SAMPLE_BITS-1:0] decay;
    logic [SAMPLE_BITS-1:0] hi;
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] peak_next;
    logic [SAMPLE_BITS-1:0] trough_next;
    logic [SAMPLE_BITS-1:0] span_next;
    logic [SAMPLE_BITS-1:0] swing_limit;
    logic [SAMPLE_BITS:0]   mid_sum;
    logic                   now_touched;
    logic                   emit;
    logic                   fire;
    logic                   out_free;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_shift_reg <= ted_pkg::DECAY_SHIFT_RESET;
            swing_shift_reg <= ted_pkg::SWING_SHIFT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ted_pkg::REG_DECAY_SHIFT: decay_shift_reg <= cfg_data;
                ted_pkg::REG_SWING_SHIFT: swing_shift_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // envelope update for the item in the input register
    always_comb
    begin
        span_now    = (peak_reg >= trough_reg) ? (peak_reg - trough_reg) : '0;
        decay       = span_now >> decay_shift_reg;
        hi          = (peak_reg >= decay) ? (peak_reg - decay) : '0;
        lo          = trough_reg + decay;
        peak_next   = (in_sample_reg > hi) ? in_sample_reg : hi;
        trough_next = (in_sample_reg < lo) ? in_sample_reg : lo;
        span_next   = (peak_next >= trough_next) ? (peak_next - trough_next) : '0;
        swing_limit = peak_next >> swing_shift_reg;
        mid_sum     = {1'b0, trough_next} + {1'b0, peak_next};
        now_touched = in_sample_reg < mid_sum[SAMPLE_BITS:1];
        emit        = primed_reg && (span_next > swing_limit)
                      && (!decided_reg || (now_touched != last_touched_reg));
    end

    assign out_free = !out_valid_reg || result_out.ready;
    // an item that yields nothing can pass even while the output is stalled
    assign fire     = in_valid_reg && (out_free || !emit);

    assign sample_in.ready    = !in_valid_reg || fire;
    assign result_out.valid   = out_valid_reg;
    assign result_out.touched = out_touched_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample_in.ready)
        begin
            in_valid_reg <= sample_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_in.valid && sample_in.ready)
        begin
            in_sample_reg <= SAMPLE_BITS'(sample_in.sample);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg         <= '0;
            trough_reg       <= '0;
            primed_reg       <= 1'b0;
            decided_reg      <= 1'b0;
            last_touched_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (!primed_reg)
            begin
                peak_reg   <= in_sample_reg;
                trough_reg <= in_sample_reg;
                primed_reg <= 1'b1;
            end
            else
            begin
                peak_reg   <= peak_next;
                trough_reg <= trough_next;
                if (emit)
                begin
                    decided_reg      <= 1'b1;
                    last_touched_reg <= now_touched;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            out_touched_reg <= now_touched;
        end
    end

    // envelope stays ordered once loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        primed_reg |-> (trough_reg <= peak_reg))
        else $error("trough above peak");

    // a pending item always matches the recorded decision
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (decided_reg && (out_touched_reg == last_touched_reg)))
        else $error("pending result disagrees with decision state");

    // a held result is never overwritten while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_out.ready) |-> !(fire && emit))
        else $error("stalled result overwritten");

endmodule
